// ----- rtl/rvd_pkg.sv -----
// ---------------------------------------------------------------------------
// RV64I decoder package
// Opcodes, function codes, operation numbers, format codes and the decoded
// instruction record shared by the decoder core and the top level.
// ---------------------------------------------------------------------------
package rvd_pkg;

  localparam int unsigned InstrWidth = 32;
  localparam int unsigned ImmWidth   = 32;
  localparam int unsigned RegIdxW    = 5;
  localparam int unsigned OpKindW    = 6;
  localparam int unsigned FormatW    = 3;

  // Major opcodes.
  localparam logic [6:0] OPC_LOAD    = 7'd3;
  localparam logic [6:0] OPC_OPIMM   = 7'd19;
  localparam logic [6:0] OPC_AUIPC   = 7'd23;
  localparam logic [6:0] OPC_OPIMM32 = 7'd27;
  localparam logic [6:0] OPC_STORE   = 7'd35;
  localparam logic [6:0] OPC_OP      = 7'd51;
  localparam logic [6:0] OPC_LUI     = 7'd55;
  localparam logic [6:0] OPC_OP32    = 7'd59;
  localparam logic [6:0] OPC_BRANCH  = 7'd99;
  localparam logic [6:0] OPC_JALR    = 7'd103;
  localparam logic [6:0] OPC_JAL     = 7'd111;

  // Function codes.
  localparam logic [2:0] F3_ADD  = 3'd0;
  localparam logic [2:0] F3_SLL  = 3'd1;
  localparam logic [2:0] F3_SLT  = 3'd2;
  localparam logic [2:0] F3_SLTU = 3'd3;
  localparam logic [2:0] F3_XOR  = 3'd4;
  localparam logic [2:0] F3_SR   = 3'd5;
  localparam logic [2:0] F3_OR   = 3'd6;
  localparam logic [2:0] F3_AND  = 3'd7;
  localparam logic [2:0] F3_BEQ  = 3'd0;
  localparam logic [2:0] F3_BNE  = 3'd1;
  localparam logic [2:0] F3_BLT  = 3'd4;
  localparam logic [2:0] F3_BGE  = 3'd5;
  localparam logic [2:0] F3_BLTU = 3'd6;
  localparam logic [2:0] F3_BGEU = 3'd7;
  localparam logic [2:0] F3_LOAD_BAD = 3'd7;
  localparam logic [6:0] F7_BASE = 7'd0;
  localparam logic [6:0] F7_ALT  = 7'd32;
  localparam logic [5:0] F6_BASE = 6'd0;
  localparam logic [5:0] F6_ALT  = 6'd16;

  // Encoding formats.
  localparam logic [FormatW-1:0] FMT_R = 3'd0;
  localparam logic [FormatW-1:0] FMT_I = 3'd1;
  localparam logic [FormatW-1:0] FMT_S = 3'd2;
  localparam logic [FormatW-1:0] FMT_B = 3'd3;
  localparam logic [FormatW-1:0] FMT_U = 3'd4;
  localparam logic [FormatW-1:0] FMT_J = 3'd5;

  // Dense operation numbers.
  localparam logic [OpKindW-1:0] K_LB    = 6'd0;
  localparam logic [OpKindW-1:0] K_ADDI  = 6'd7;
  localparam logic [OpKindW-1:0] K_SLLI  = 6'd8;
  localparam logic [OpKindW-1:0] K_SLTI  = 6'd9;
  localparam logic [OpKindW-1:0] K_SLTIU = 6'd10;
  localparam logic [OpKindW-1:0] K_XORI  = 6'd11;
  localparam logic [OpKindW-1:0] K_SRLI  = 6'd12;
  localparam logic [OpKindW-1:0] K_SRAI  = 6'd13;
  localparam logic [OpKindW-1:0] K_ORI   = 6'd14;
  localparam logic [OpKindW-1:0] K_ANDI  = 6'd15;
  localparam logic [OpKindW-1:0] K_LUI   = 6'd16;
  localparam logic [OpKindW-1:0] K_AUIPC = 6'd17;
  localparam logic [OpKindW-1:0] K_ADDIW = 6'd18;
  localparam logic [OpKindW-1:0] K_SLLIW = 6'd19;
  localparam logic [OpKindW-1:0] K_SRLIW = 6'd20;
  localparam logic [OpKindW-1:0] K_SRAIW = 6'd21;
  localparam logic [OpKindW-1:0] K_SB    = 6'd22;
  localparam logic [OpKindW-1:0] K_ADD   = 6'd26;
  localparam logic [OpKindW-1:0] K_SUB   = 6'd27;
  localparam logic [OpKindW-1:0] K_SLL   = 6'd28;
  localparam logic [OpKindW-1:0] K_SLT   = 6'd29;
  localparam logic [OpKindW-1:0] K_SLTU  = 6'd30;
  localparam logic [OpKindW-1:0] K_XOR   = 6'd31;
  localparam logic [OpKindW-1:0] K_SRL   = 6'd32;
  localparam logic [OpKindW-1:0] K_SRA   = 6'd33;
  localparam logic [OpKindW-1:0] K_OR    = 6'd34;
  localparam logic [OpKindW-1:0] K_AND   = 6'd35;
  localparam logic [OpKindW-1:0] K_ADDW  = 6'd36;
  localparam logic [OpKindW-1:0] K_SUBW  = 6'd37;
  localparam logic [OpKindW-1:0] K_SLLW  = 6'd38;
  localparam logic [OpKindW-1:0] K_SRLW  = 6'd39;
  localparam logic [OpKindW-1:0] K_SRAW  = 6'd40;
  localparam logic [OpKindW-1:0] K_BEQ   = 6'd41;
  localparam logic [OpKindW-1:0] K_BNE   = 6'd42;
  localparam logic [OpKindW-1:0] K_BLT   = 6'd43;
  localparam logic [OpKindW-1:0] K_BGE   = 6'd44;
  localparam logic [OpKindW-1:0] K_BLTU  = 6'd45;
  localparam logic [OpKindW-1:0] K_BGEU  = 6'd46;
  localparam logic [OpKindW-1:0] K_JALR  = 6'd47;
  localparam logic [OpKindW-1:0] K_JAL   = 6'd48;
  localparam logic [OpKindW-1:0] K_LAST  = K_JAL;

  typedef struct packed {
    logic                legal;
    logic [OpKindW-1:0]  op_kind;
    logic [FormatW-1:0]  format;
    logic [RegIdxW-1:0]  src1_index;
    logic [RegIdxW-1:0]  src2_index;
    logic [RegIdxW-1:0]  dest_index;
    logic                uses_src1;
    logic                uses_src2;
    logic                writes_dest;
    logic [ImmWidth-1:0] immediate;
  } dec_t;

endpackage

// ----- rtl/rv64i_instruction_decoder_unit.sv -----
// ---------------------------------------------------------------------------
// RV64I instruction decoder unit
// Two-register streaming decoder for the 49 RV64I base operations.
// ---------------------------------------------------------------------------
// Each request on the in_ channel carries one 32-bit instruction word and
// produces exactly one decoded result on the out_ channel, in order. The word
// is captured in an input register, decoded by a single level of
// combinational logic, and the result is captured in an output register.
// Throughput is one instruction per cycle while the output is not stalled:
// in_tready stays high as long as the decode stage is empty or the output
// register is free or is being drained in the same cycle, and a stalled
// output holds both registers in place without losing or repeating a
// request. Illegal encodings are not dropped; they are returned with the
// legal flag low and op_kind, format, the use flags and the immediate all
// zero, while the register index fields still carry the raw instruction
// bits. The write flag is set even when the destination is x0. There is no
// configuration and no state beyond the two pipeline registers.
module rv64i_instruction_decoder_unit (
  input  logic        clk,
  input  logic        rst_n,
  // in_tdata: instr_word[31:0]
  input  logic [31:0] in_tdata,
  input  logic        in_tvalid,
  output logic        in_tready,
  // out_tdata: src1_index[4:0], src2_index[9:5], dest_index[14:10],
  //   uses_src1[15], uses_src2[16], writes_dest[17], immediate[49:18],
  //   zero fill[55:50]
  output logic [55:0] out_tdata,
  // out_tuser: legal[0], op_kind[6:1], format[9:7]
  output logic [9:0]  out_tuser,
  output logic        out_tvalid,
  input  logic        out_tready
);
  import rvd_pkg::*;

  logic                  s1_valid_r, s1_valid_nxt;
  logic [InstrWidth-1:0] s1_instr_r;
  logic                  out_valid_r, out_valid_nxt;
  dec_t                  out_dec_r;
  dec_t                  dec;
  logic                  in_fire;
  logic                  s1_adv;

  // The decode stage moves forward when the output register is empty or is
  // being read in this cycle.
  assign s1_adv    = !out_valid_r || out_tready;
  assign in_tready = !s1_valid_r || s1_adv;
  assign in_fire   = in_tvalid && in_tready;

  rvd_decode u_decode (
    .instr (s1_instr_r),
    .dec   (dec)
  );

  always_comb begin
    s1_valid_nxt  = s1_valid_r;
    out_valid_nxt = out_valid_r;
    if (s1_adv) begin
      out_valid_nxt = s1_valid_r;
    end
    if (in_tready) begin
      s1_valid_nxt = in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_instr_r <= in_tdata;
    end
    if (s1_adv && s1_valid_r) begin
      out_dec_r <= dec;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = {out_dec_r.format, out_dec_r.op_kind, out_dec_r.legal};
  assign out_tdata  = {6'b0, out_dec_r.immediate, out_dec_r.writes_dest,
                       out_dec_r.uses_src2, out_dec_r.uses_src1,
                       out_dec_r.dest_index, out_dec_r.src2_index,
                       out_dec_r.src1_index};

`ifndef SYNTHESIS
  // An illegal result carries no decode information.
  a_illegal_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_dec_r.legal) |->
      (out_dec_r.op_kind == K_LB && out_dec_r.format == FMT_R &&
       out_dec_r.immediate == '0 && !out_dec_r.uses_src1 &&
       !out_dec_r.uses_src2 && !out_dec_r.writes_dest))
    else $error("illegal result carries nonzero decode fields");

  // Legal results stay within the defined operation numbers and formats.
  a_kind_range: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_dec_r.legal) |->
      (out_dec_r.op_kind <= K_LAST && out_dec_r.format <= FMT_J))
    else $error("operation number or format out of range");

  // Upper-immediate and jump formats never read a source register.
  a_uj_no_src: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (out_dec_r.format == FMT_U || out_dec_r.format == FMT_J)) |->
      (!out_dec_r.uses_src1 && !out_dec_r.uses_src2))
    else $error("U or J format marked as reading a source");

  // An accepted request always lands in the decode stage.
  a_in_capture: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> (s1_valid_r && s1_instr_r == $past(in_tdata)))
    else $error("accepted request not captured");

  // A blocked decode stage keeps its instruction.
  a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && !s1_adv) |=> (s1_valid_r && $stable(s1_instr_r)))
    else $error("decode stage lost its instruction while stalled");
`endif

endmodule

// ----- rtl/rvd_decode.sv -----
// ---------------------------------------------------------------------------
// RV64I decoder core
// Combinational decode of one registered instruction word into a dec_t record.
// ---------------------------------------------------------------------------
module rvd_decode (
  input  logic [rvd_pkg::InstrWidth-1:0] instr,
  output rvd_pkg::dec_t                  dec
);
  import rvd_pkg::*;

  logic [6:0]          opc;
  logic [2:0]          f3;
  logic [6:0]          f7;
  logic [5:0]          f6;
  logic [ImmWidth-1:0] imm_i, imm_s, imm_b, imm_u, imm_j, sh6, sh5;
  logic                legal;
  logic [OpKindW-1:0]  kind;
  logic [FormatW-1:0]  fmt;
  logic [ImmWidth-1:0] imm;

  assign opc = instr[6:0];
  assign f3  = instr[14:12];
  assign f7  = instr[31:25];
  assign f6  = instr[31:26];

  assign imm_i = {{20{instr[31]}}, instr[31:20]};
  assign imm_s = {{20{instr[31]}}, instr[31:25], instr[11:7]};
  assign imm_b = {{19{instr[31]}}, instr[31], instr[7], instr[30:25], instr[11:8], 1'b0};
  assign imm_u = {instr[31:12], 12'b0};
  assign imm_j = {{11{instr[31]}}, instr[31], instr[19:12], instr[20], instr[30:21], 1'b0};
  assign sh6   = {26'b0, instr[25:20]};
  assign sh5   = {27'b0, instr[24:20]};

  always_comb begin
    legal = 1'b0;
    kind  = K_LB;
    fmt   = FMT_R;
    imm   = '0;
    unique case (opc)
      OPC_LOAD: begin
        if (f3 != F3_LOAD_BAD) begin
          legal = 1'b1; kind = K_LB + {3'b0, f3}; fmt = FMT_I; imm = imm_i;
        end
      end
      OPC_OPIMM: begin
        legal = 1'b1; fmt = FMT_I; imm = imm_i;
        unique case (f3)
          F3_ADD:  kind = K_ADDI;
          F3_SLT:  kind = K_SLTI;
          F3_SLTU: kind = K_SLTIU;
          F3_XOR:  kind = K_XORI;
          F3_OR:   kind = K_ORI;
          F3_AND:  kind = K_ANDI;
          F3_SLL: begin
            if (f6 == F6_BASE) begin
              kind = K_SLLI; imm = sh6;
            end else begin
              legal = 1'b0;
            end
          end
          default: begin
            // Right shifts: funct6 picks logical or arithmetic.
            if (f6 == F6_BASE) begin
              kind = K_SRLI; imm = sh6;
            end else if (f6 == F6_ALT) begin
              kind = K_SRAI; imm = sh6;
            end else begin
              legal = 1'b0;
            end
          end
        endcase
      end
      OPC_LUI: begin
        legal = 1'b1; kind = K_LUI; fmt = FMT_U; imm = imm_u;
      end
      OPC_AUIPC: begin
        legal = 1'b1; kind = K_AUIPC; fmt = FMT_U; imm = imm_u;
      end
      OPC_OPIMM32: begin
        fmt = FMT_I;
        if (f3 == F3_ADD) begin
          legal = 1'b1; kind = K_ADDIW; imm = imm_i;
        end else if (f3 == F3_SLL && f7 == F7_BASE) begin
          legal = 1'b1; kind = K_SLLIW; imm = sh5;
        end else if (f3 == F3_SR && f7 == F7_BASE) begin
          legal = 1'b1; kind = K_SRLIW; imm = sh5;
        end else if (f3 == F3_SR && f7 == F7_ALT) begin
          legal = 1'b1; kind = K_SRAIW; imm = sh5;
        end
      end
      OPC_STORE: begin
        if (!f3[2]) begin
          legal = 1'b1; kind = K_SB + {4'b0, f3[1:0]}; fmt = FMT_S; imm = imm_s;
        end
      end
      OPC_OP: begin
        fmt = FMT_R;
        if (f7 == F7_BASE) begin
          legal = 1'b1;
          unique case (f3)
            F3_ADD:  kind = K_ADD;
            F3_SLL:  kind = K_SLL;
            F3_SLT:  kind = K_SLT;
            F3_SLTU: kind = K_SLTU;
            F3_XOR:  kind = K_XOR;
            F3_SR:   kind = K_SRL;
            F3_OR:   kind = K_OR;
            default: kind = K_AND;
          endcase
        end else if (f7 == F7_ALT && f3 == F3_ADD) begin
          legal = 1'b1; kind = K_SUB;
        end else if (f7 == F7_ALT && f3 == F3_SR) begin
          legal = 1'b1; kind = K_SRA;
        end
      end
      OPC_OP32: begin
        fmt = FMT_R;
        if (f7 == F7_BASE && f3 == F3_ADD) begin
          legal = 1'b1; kind = K_ADDW;
        end else if (f7 == F7_ALT && f3 == F3_ADD) begin
          legal = 1'b1; kind = K_SUBW;
        end else if (f7 == F7_BASE && f3 == F3_SLL) begin
          legal = 1'b1; kind = K_SLLW;
        end else if (f7 == F7_BASE && f3 == F3_SR) begin
          legal = 1'b1; kind = K_SRLW;
        end else if (f7 == F7_ALT && f3 == F3_SR) begin
          legal = 1'b1; kind = K_SRAW;
        end
      end
      OPC_BRANCH: begin
        legal = 1'b1; fmt = FMT_B; imm = imm_b;
        unique case (f3)
          F3_BEQ:  kind = K_BEQ;
          F3_BNE:  kind = K_BNE;
          F3_BLT:  kind = K_BLT;
          F3_BGE:  kind = K_BGE;
          F3_BLTU: kind = K_BLTU;
          F3_BGEU: kind = K_BGEU;
          default: legal = 1'b0;
        endcase
      end
      OPC_JALR: begin
        if (f3 == F3_ADD) begin
          legal = 1'b1; kind = K_JALR; fmt = FMT_I; imm = imm_i;
        end
      end
      OPC_JAL: begin
        legal = 1'b1; kind = K_JAL; fmt = FMT_J; imm = imm_j;
      end
      default: legal = 1'b0;
    endcase

    // An illegal word reports zero op_kind, format and immediate.
    if (!legal) begin
      kind = K_LB;
      fmt  = FMT_R;
      imm  = '0;
    end
  end

  always_comb begin
    dec.legal       = legal;
    dec.op_kind     = kind;
    dec.format      = fmt;
    dec.src1_index  = instr[19:15];
    dec.src2_index  = instr[24:20];
    dec.dest_index  = instr[11:7];
    dec.uses_src1   = legal && fmt != FMT_U && fmt != FMT_J;
    dec.uses_src2   = legal && (fmt == FMT_R || fmt == FMT_S || fmt == FMT_B);
    dec.writes_dest = legal && fmt != FMT_S && fmt != FMT_B;
    dec.immediate   = imm;
  end

endmodule
